@@ sv/spc_pkg.sv @@
// Shared constants, types and sign helpers for the segment pair classifier.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int FIELD_W     = 64;
    localparam int COORD_WIDTH = 64;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MAG_W       = COORD_WIDTH;
    localparam int HALF_W      = (MAG_W + 1) / 2;
    localparam int PROD_W      = 4 * HALF_W;

    localparam int NUM_STAGES  = 7;
    localparam int NUM_DIFF    = 6;
    localparam int NUM_MAG     = 5;
    localparam int NUM_ORIENT  = 4;
    localparam int NUM_PROD    = 2 * NUM_ORIENT;

    // point indexes
    localparam int PT_A = 0;
    localparam int PT_B = 1;
    localparam int PT_C = 2;
    localparam int PT_D = 3;

    // coordinate differences, first point minus second
    localparam int D_BA = 0;
    localparam int D_CA = 1;
    localparam int D_DA = 2;
    localparam int D_DC = 3;
    localparam int D_BC = 4;
    localparam int D_DB = 5;

    // orientation k: cross(q, r) with q and r taken from the difference list
    localparam int ORIENT_Q [NUM_ORIENT] = '{D_BA, D_BA, D_DC, D_DC};
    localparam int ORIENT_R [NUM_ORIENT] = '{D_CA, D_DA, D_CA, D_BC};
    localparam bit ORIENT_FLIP_R [NUM_ORIENT] = '{1'b0, 1'b0, 1'b1, 1'b0};

    typedef enum logic [1:0] {
        REL_DISJOINT = 2'd0,
        REL_CROSS    = 2'd1,
        REL_TOUCH    = 2'd2,
        REL_OVERLAP  = 2'd3
    } rel_t;

    typedef struct packed {
        logic neg;
        logic nz;
    } sgn_t;

    typedef struct packed {
        sgn_t [NUM_DIFF-1:0] x;
        sgn_t [NUM_DIFF-1:0] y;
    } sign_set_t;

    typedef struct packed {
        logic mul;
        logic add_mid;
        logic add_full;
    } mul_en_t;

    function automatic sgn_t flip_sgn(input sgn_t s);
        sgn_t r;
        r.nz  = s.nz;
        r.neg = s.nz & ~s.neg;
        return r;
    endfunction

    function automatic sgn_t mul_sgn(input sgn_t a, input sgn_t b);
        sgn_t r;
        r.nz  = a.nz & b.nz;
        r.neg = a.nz & b.nz & (a.neg ^ b.neg);
        return r;
    endfunction

    function automatic logic is_pos(input sgn_t s);
        return s.nz & ~s.neg;
    endfunction

    // both differences nonzero with the same sign: point lies beyond both ends
    function automatic logic outside(input sgn_t p, input sgn_t q);
        return (is_pos(p) & is_pos(q)) | (p.neg & q.neg);
    endfunction

    function automatic sgn_t orient_sign(input sgn_t s1, input sgn_t s2,
                                         input logic [PROD_W-1:0] p1,
                                         input logic [PROD_W-1:0] p2);
        sgn_t r;
        priority if (!s1.nz)
            r = flip_sgn(s2);
        else if (!s2.nz)
            r = s1;
        else if (s1.neg != s2.neg)
            r = s1;
        else if (p1 > p2)
            r = s1;
        else if (p1 == p2)
            r = '0;
        else
            r = flip_sgn(s1);
        return r;
    endfunction

endpackage

@@ sv/spc_mul.sv @@
// Three-stage unsigned multiplier built from half-width partial products.
`timescale 1ns / 1ps

module spc_mul import spc_pkg::*; (
    input  logic              clk,
    input  mul_en_t           en,
    input  logic [MAG_W-1:0]  a,
    input  logic [MAG_W-1:0]  b,
    output logic [PROD_W-1:0] p
);

    logic [2*HALF_W-1:0] a_ext;
    logic [2*HALF_W-1:0] b_ext;
    logic [2*HALF_W-1:0] pp00_reg;
    logic [2*HALF_W-1:0] pp01_reg;
    logic [2*HALF_W-1:0] pp10_reg;
    logic [2*HALF_W-1:0] pp11_reg;
    logic [PROD_W-1:0]   outer_reg;
    logic [2*HALF_W:0]   mid_reg;
    logic [PROD_W-1:0]   p_reg;

    assign a_ext = (2*HALF_W)'(a);
    assign b_ext = (2*HALF_W)'(b);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            pp00_reg <= a_ext[HALF_W-1:0]        * b_ext[HALF_W-1:0];
            pp01_reg <= a_ext[HALF_W-1:0]        * b_ext[2*HALF_W-1:HALF_W];
            pp10_reg <= a_ext[2*HALF_W-1:HALF_W] * b_ext[HALF_W-1:0];
            pp11_reg <= a_ext[2*HALF_W-1:HALF_W] * b_ext[2*HALF_W-1:HALF_W];
        end
        if (en.add_mid)
        begin
            outer_reg <= {pp11_reg, pp00_reg};
            mid_reg   <= (2*HALF_W+1)'(pp01_reg) + (2*HALF_W+1)'(pp10_reg);
        end
        if (en.add_full)
            p_reg <= outer_reg + (PROD_W'(mid_reg) << HALF_W);
    end

    assign p = p_reg;

endmodule

@@ sv/segment_pair_classifier_top.sv @@
// Segment pair classifier: relation of segments AB and CD, seven-stage pipeline.
`timescale 1ns / 1ps

// Takes one pair of segments per cycle while pair_stall is low and returns the
// relation code (disjoint, proper crossing, endpoint touch, collinear overlap).
// Coordinates are signed, only the low COORD_WIDTH bits are used. The stages
// follow the orientation path: difference, magnitude, partial products,
// two adder stages, magnitude compare, classification. Empty stages close up
// under a stall on the result side, so pairs are still taken while a result
// waits, until the pipeline is full.

module segment_pair_classifier_top import spc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_stall,
    input  logic [FIELD_W-1:0] ax,
    input  logic [FIELD_W-1:0] ay,
    input  logic [FIELD_W-1:0] bx,
    input  logic [FIELD_W-1:0] by,
    input  logic [FIELD_W-1:0] cx,
    input  logic [FIELD_W-1:0] cy,
    input  logic [FIELD_W-1:0] dx,
    input  logic [FIELD_W-1:0] dy,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         relation
);

    logic [NUM_STAGES:1] en;
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] valid_next;
    logic [NUM_STAGES:1] valid_prev;

    logic signed [DIFF_W-1:0] pt_x [4];
    logic signed [DIFF_W-1:0] pt_y [4];
    logic signed [DIFF_W-1:0] diff_x_next [NUM_DIFF];
    logic signed [DIFF_W-1:0] diff_y_next [NUM_DIFF];
    logic signed [DIFF_W-1:0] diff_x_reg [NUM_DIFF];
    logic signed [DIFF_W-1:0] diff_y_reg [NUM_DIFF];

    logic signed [DIFF_W-1:0] abs_x [NUM_MAG];
    logic signed [DIFF_W-1:0] abs_y [NUM_MAG];
    logic [MAG_W-1:0]         mag_x_reg [NUM_MAG];
    logic [MAG_W-1:0]         mag_y_reg [NUM_MAG];
    sign_set_t                sg_next;
    sign_set_t                sg_reg [2:6];

    mul_en_t                  mul_en;
    logic [PROD_W-1:0]        prod [NUM_PROD];

    sgn_t [NUM_ORIENT-1:0]    orient_next;
    sgn_t [NUM_ORIENT-1:0]    orient_reg;

    rel_t                     rel_next;
    rel_t                     relation_reg;

    // stage enables: a stage moves when empty or when the next one moves
    assign en[NUM_STAGES] = ~valid_reg[NUM_STAGES] | ~result_stall;
    for (genvar k = 1; k < NUM_STAGES; k++)
    begin : g_en
        assign en[k] = ~valid_reg[k] | en[k+1];
    end

    assign valid_prev = {valid_reg[NUM_STAGES-1:1], pair_valid};
    assign valid_next = (en & valid_prev) | (~en & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign pair_stall   = ~en[1];
    assign result_valid = valid_reg[NUM_STAGES];
    assign relation     = relation_reg;

    // stage 1: sign extension and coordinate differences
    assign pt_x[PT_A] = {ax[COORD_WIDTH-1], ax[COORD_WIDTH-1:0]};
    assign pt_y[PT_A] = {ay[COORD_WIDTH-1], ay[COORD_WIDTH-1:0]};
    assign pt_x[PT_B] = {bx[COORD_WIDTH-1], bx[COORD_WIDTH-1:0]};
    assign pt_y[PT_B] = {by[COORD_WIDTH-1], by[COORD_WIDTH-1:0]};
    assign pt_x[PT_C] = {cx[COORD_WIDTH-1], cx[COORD_WIDTH-1:0]};
    assign pt_y[PT_C] = {cy[COORD_WIDTH-1], cy[COORD_WIDTH-1:0]};
    assign pt_x[PT_D] = {dx[COORD_WIDTH-1], dx[COORD_WIDTH-1:0]};
    assign pt_y[PT_D] = {dy[COORD_WIDTH-1], dy[COORD_WIDTH-1:0]};

    always_comb
    begin
        diff_x_next[D_BA] = pt_x[PT_B] - pt_x[PT_A];
        diff_y_next[D_BA] = pt_y[PT_B] - pt_y[PT_A];
        diff_x_next[D_CA] = pt_x[PT_C] - pt_x[PT_A];
        diff_y_next[D_CA] = pt_y[PT_C] - pt_y[PT_A];
        diff_x_next[D_DA] = pt_x[PT_D] - pt_x[PT_A];
        diff_y_next[D_DA] = pt_y[PT_D] - pt_y[PT_A];
        diff_x_next[D_DC] = pt_x[PT_D] - pt_x[PT_C];
        diff_y_next[D_DC] = pt_y[PT_D] - pt_y[PT_C];
        diff_x_next[D_BC] = pt_x[PT_B] - pt_x[PT_C];
        diff_y_next[D_BC] = pt_y[PT_B] - pt_y[PT_C];
        diff_x_next[D_DB] = pt_x[PT_D] - pt_x[PT_B];
        diff_y_next[D_DB] = pt_y[PT_D] - pt_y[PT_B];
    end

    // stage 2: sign and magnitude
    always_comb
    begin
        for (int i = 0; i < NUM_DIFF; i++)
        begin
            sg_next.x[i].neg = diff_x_reg[i][DIFF_W-1];
            sg_next.x[i].nz  = |diff_x_reg[i];
            sg_next.y[i].neg = diff_y_reg[i][DIFF_W-1];
            sg_next.y[i].nz  = |diff_y_reg[i];
        end
        for (int i = 0; i < NUM_MAG; i++)
        begin
            abs_x[i] = diff_x_reg[i][DIFF_W-1] ? -diff_x_reg[i] : diff_x_reg[i];
            abs_y[i] = diff_y_reg[i][DIFF_W-1] ? -diff_y_reg[i] : diff_y_reg[i];
        end
    end

    // stages 3 to 5: cross product terms
    assign mul_en.mul      = en[3];
    assign mul_en.add_mid  = en[4];
    assign mul_en.add_full = en[5];

    for (genvar k = 0; k < NUM_ORIENT; k++)
    begin : g_orient
        sgn_t s1;
        sgn_t s2;
        sgn_t rx;
        sgn_t ry;

        spc_mul u_mul_p1 (
            .clk (clk),
            .en  (mul_en),
            .a   (mag_x_reg[ORIENT_Q[k]]),
            .b   (mag_y_reg[ORIENT_R[k]]),
            .p   (prod[2*k])
        );

        spc_mul u_mul_p2 (
            .clk (clk),
            .en  (mul_en),
            .a   (mag_y_reg[ORIENT_Q[k]]),
            .b   (mag_x_reg[ORIENT_R[k]]),
            .p   (prod[2*k+1])
        );

        // stage 6: exact orientation sign
        assign rx = ORIENT_FLIP_R[k] ? flip_sgn(sg_reg[5].x[ORIENT_R[k]])
                                     : sg_reg[5].x[ORIENT_R[k]];
        assign ry = ORIENT_FLIP_R[k] ? flip_sgn(sg_reg[5].y[ORIENT_R[k]])
                                     : sg_reg[5].y[ORIENT_R[k]];
        assign s1 = mul_sgn(sg_reg[5].x[ORIENT_Q[k]], ry);
        assign s2 = mul_sgn(sg_reg[5].y[ORIENT_Q[k]], rx);
        assign orient_next[k] = orient_sign(s1, s2, prod[2*k], prod[2*k+1]);
    end

    // stage 7: classification
    always_comb
    begin
        sign_set_t           sg;
        sgn_t [NUM_DIFF-1:0] sel;
        logic                degen;
        logic                use_x;
        logic                lt;
        logic                le;
        logic                box_a;
        logic                box_b;
        logic                box_c;
        logic                box_d;
        logic                touch;
        logic                crossing;

        sg    = sg_reg[6];
        degen = ~sg.x[D_BA].nz & ~sg.y[D_BA].nz;
        use_x = sg.x[D_BA].nz;
        sel   = use_x ? sg.x : sg.y;

        lt = (is_pos(sel[D_CA]) | is_pos(sel[D_DA]) | sel[D_BC].neg | is_pos(sel[D_DB]))
           & (sel[D_CA].neg | is_pos(sel[D_BC]) | sel[D_DA].neg | sel[D_DB].neg)
           & sel[D_DC].nz;
        le = (~sel[D_CA].neg | ~sel[D_DA].neg | ~is_pos(sel[D_BC]) | ~sel[D_DB].neg)
           & (~is_pos(sel[D_CA]) | ~sel[D_BC].neg | ~is_pos(sel[D_DA])
              | ~is_pos(sel[D_DB]));

        box_c = ~outside(sg.x[D_CA], flip_sgn(sg.x[D_BC]))
              & ~outside(sg.y[D_CA], flip_sgn(sg.y[D_BC]));
        box_d = ~outside(sg.x[D_DA], sg.x[D_DB]) & ~outside(sg.y[D_DA], sg.y[D_DB]);
        box_a = ~outside(sg.x[D_CA], sg.x[D_DA]) & ~outside(sg.y[D_CA], sg.y[D_DA]);
        box_b = ~outside(sg.x[D_BC], flip_sgn(sg.x[D_DB]))
              & ~outside(sg.y[D_BC], flip_sgn(sg.y[D_DB]));

        touch = (~orient_reg[0].nz & box_c) | (~orient_reg[1].nz & box_d)
              | (~orient_reg[2].nz & box_a) | (~orient_reg[3].nz & box_b);
        crossing = orient_reg[0].nz & orient_reg[1].nz & orient_reg[2].nz
                 & orient_reg[3].nz
                 & (orient_reg[0].neg != orient_reg[1].neg)
                 & (orient_reg[2].neg != orient_reg[3].neg);

        priority if (degen)
            rel_next = (~orient_reg[2].nz & box_a) ? REL_TOUCH : REL_DISJOINT;
        else if (~orient_reg[0].nz & ~orient_reg[1].nz)
            rel_next = lt ? REL_OVERLAP : (le ? REL_TOUCH : REL_DISJOINT);
        else if (crossing)
            rel_next = REL_CROSS;
        else if (touch)
            rel_next = REL_TOUCH;
        else
            rel_next = REL_DISJOINT;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            diff_x_reg <= diff_x_next;
            diff_y_reg <= diff_y_next;
        end
        if (en[2])
        begin
            sg_reg[2] <= sg_next;
            for (int i = 0; i < NUM_MAG; i++)
            begin
                mag_x_reg[i] <= abs_x[i][MAG_W-1:0];
                mag_y_reg[i] <= abs_y[i][MAG_W-1:0];
            end
        end
        if (en[3])
            sg_reg[3] <= sg_reg[2];
        if (en[4])
            sg_reg[4] <= sg_reg[3];
        if (en[5])
            sg_reg[5] <= sg_reg[4];
        if (en[6])
        begin
            sg_reg[6]  <= sg_reg[5];
            orient_reg <= orient_next;
        end
        if (en[7])
            relation_reg <= rel_next;
    end

endmodule

@@ tb/segment_pair_classifier_checker.sv @@
// Checker for the segment pair classifier: predicts each relation code and compares transfers.
`timescale 1ns / 1ps

module segment_pair_classifier_checker import spc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    input  logic               pair_stall,
    input  logic [FIELD_W-1:0] ax,
    input  logic [FIELD_W-1:0] ay,
    input  logic [FIELD_W-1:0] bx,
    input  logic [FIELD_W-1:0] by,
    input  logic [FIELD_W-1:0] cx,
    input  logic [FIELD_W-1:0] cy,
    input  logic [FIELD_W-1:0] dx,
    input  logic [FIELD_W-1:0] dy,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [1:0]         relation,
    output int                 fail_count,
    output int                 pending,
    output int                 pairs_seen,
    output logic [3:0][31:0]   relation_hits
);

    localparam int XW         = 2 * COORD_WIDTH + 4;
    localparam int REPORT_MAX = 100;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [XW-1:0]          wide_t;

    typedef struct packed {
        rel_t        rel;
        logic [31:0] tag;
    } relation_due_t;

    relation_due_t relation_due_q [$];

    function automatic coord_t coord_of(input logic [FIELD_W-1:0] raw);
        return coord_t'(signed'(raw[COORD_WIDTH-1:0]));
    endfunction

    // sign of cross(q - p, r - p), exact
    function automatic int turn(input coord_t px, input coord_t py, input coord_t qx,
                                input coord_t qy, input coord_t rx, input coord_t ry);
        wide_t ux, uy, vx, vy, cp;
        ux = wide_t'(qx) - wide_t'(px);
        uy = wide_t'(qy) - wide_t'(py);
        vx = wide_t'(rx) - wide_t'(px);
        vy = wide_t'(ry) - wide_t'(py);
        cp = ux * vy - uy * vx;
        if (cp > 0)
            return 1;
        if (cp < 0)
            return -1;
        return 0;
    endfunction

    function automatic bit in_span(input coord_t px, input coord_t py, input coord_t sx,
                                   input coord_t sy, input coord_t ex, input coord_t ey);
        coord_t lx, hx, ly, hy;
        lx = (sx < ex) ? sx : ex;
        hx = (sx < ex) ? ex : sx;
        ly = (sy < ey) ? sy : ey;
        hy = (sy < ey) ? ey : sy;
        return px >= lx && px <= hx && py >= ly && py <= hy;
    endfunction

    function automatic rel_t segment_relation(input coord_t xa, input coord_t ya,
                                              input coord_t xb, input coord_t yb,
                                              input coord_t xc, input coord_t yc,
                                              input coord_t xd, input coord_t yd);
        int     o1, o2, o3, o4;
        coord_t l1, h1, l2, h2, t, lo, hi;
        o1 = turn(xa, ya, xb, yb, xc, yc);
        o2 = turn(xa, ya, xb, yb, xd, yd);
        o3 = turn(xc, yc, xd, yd, xa, ya);
        o4 = turn(xc, yc, xd, yd, xb, yb);
        if (xa == xb && ya == yb)
            return (o3 == 0 && in_span(xa, ya, xc, yc, xd, yd)) ? REL_TOUCH : REL_DISJOINT;
        if (o1 == 0 && o2 == 0)
        begin
            if (xa != xb)
            begin
                l1 = xa; h1 = xb; l2 = xc; h2 = xd;
            end
            else
            begin
                l1 = ya; h1 = yb; l2 = yc; h2 = yd;
            end
            if (l1 > h1)
            begin
                t = l1; l1 = h1; h1 = t;
            end
            if (l2 > h2)
            begin
                t = l2; l2 = h2; h2 = t;
            end
            lo = (l1 > l2) ? l1 : l2;
            hi = (h1 < h2) ? h1 : h2;
            if (lo < hi)
                return REL_OVERLAP;
            if (lo == hi)
                return REL_TOUCH;
            return REL_DISJOINT;
        end
        if (o1 != 0 && o2 != 0 && o3 != 0 && o4 != 0 && o1 != o2 && o3 != o4)
            return REL_CROSS;
        if ((o1 == 0 && in_span(xc, yc, xa, ya, xb, yb)) ||
            (o2 == 0 && in_span(xd, yd, xa, ya, xb, yb)) ||
            (o3 == 0 && in_span(xa, ya, xc, yc, xd, yd)) ||
            (o4 == 0 && in_span(xb, yb, xc, yc, xd, yd)))
            return REL_TOUCH;
        return REL_DISJOINT;
    endfunction

    always @(posedge clk)
    begin : watch
        relation_due_t due;
        if (!rst_n)
        begin
            relation_due_q.delete();
            fail_count    <= 0;
            pending       <= 0;
            pairs_seen    <= 0;
            relation_hits <= '0;
        end
        else
        begin
            if (pair_valid && !pair_stall)
            begin
                due.rel = segment_relation(coord_of(ax), coord_of(ay), coord_of(bx),
                                           coord_of(by), coord_of(cx), coord_of(cy),
                                           coord_of(dx), coord_of(dy));
                due.tag = pairs_seen;
                relation_due_q.push_back(due);
                pairs_seen <= pairs_seen + 1;
            end
            if (result_valid && !result_stall)
            begin
                if (relation_due_q.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: result transfer with none expected, got %0d",
                                 $time, relation);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    due = relation_due_q.pop_front();
                    if (relation !== due.rel)
                    begin
                        if (fail_count < REPORT_MAX)
                            $display("%0t: pair %0d relation expected %0d, got %0d",
                                     $time, due.tag, due.rel, relation);
                        fail_count <= fail_count + 1;
                    end
                end
                if (!$isunknown(relation))
                    relation_hits[relation] <= relation_hits[relation] + 1;
            end
            pending <= relation_due_q.size();
        end
    end

endmodule

@@ tb/segment_pair_classifier_top_test.sv @@
// Testbench top for the segment pair classifier: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module segment_pair_classifier_top_test;
    import spc_pkg::*;

    typedef logic [FIELD_W-1:0] word_t;

    localparam word_t COORD_MAX   = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam word_t COORD_MIN   = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam int    HOLD_CYCLES = 150;
    localparam int    BLOCKS      = 8;
    localparam int    BLOCK_PAIRS = 250;

    logic              clk;
    logic              rst_n;
    logic              pair_valid;
    logic              pair_stall;
    word_t             ax, ay, bx, by, cx, cy, dx, dy;
    logic              result_valid;
    logic              result_stall;
    logic [1:0]        relation;
    int                fail_count;
    int                pending;
    int                pairs_seen;
    logic [3:0][31:0]  relation_hits;

    bit    idle_on;
    bit    long_hold;
    word_t px [4];
    word_t py [4];

    segment_pair_classifier_top i_dut (.*);

    segment_pair_classifier_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("segment_pair_classifier_top_test failed");
        $finish;
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random magnitude, roughly 2^(63 - shift) at most
    function automatic word_t sized_val(input int min_shift);
        word_t w;
        w = {$urandom, $urandom};
        return word_t'($signed(w) >>> $urandom_range(min_shift, 63));
    endfunction

    function automatic word_t small_val(input int span);
        return word_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic word_t corner_val();
        case ($urandom_range(0, 7))
            0: return COORD_MIN;
            1: return COORD_MIN + 1;
            2: return '1;
            3: return '0;
            4: return 1;
            5: return COORD_MAX - 1;
            6: return COORD_MAX;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic swap_segments();
        word_t t;
        t = px[PT_A]; px[PT_A] = px[PT_C]; px[PT_C] = t;
        t = py[PT_A]; py[PT_A] = py[PT_C]; py[PT_C] = t;
        t = px[PT_B]; px[PT_B] = px[PT_D]; px[PT_D] = t;
        t = py[PT_B]; py[PT_B] = py[PT_D]; py[PT_D] = t;
    endtask

    task automatic make_pair();
        int    shape, t;
        word_t ox, oy, vx, vy;
        shape = $urandom_range(0, 99);
        if (shape < 10)
        begin
            for (int k = 0; k < 4; k++)
            begin
                px[k] = {$urandom, $urandom};
                py[k] = {$urandom, $urandom};
            end
        end
        else if (shape < 30)
        begin
            for (int k = 0; k < 4; k++)
            begin
                px[k] = small_val(6);
                py[k] = small_val(6);
            end
        end
        else if (shape < 55)
        begin
            // points on one line, one point sometimes nudged off it by one unit in y
            ox = sized_val(2);
            oy = sized_val(2);
            vx = ($urandom_range(0, 4) == 0) ? '0 : sized_val(24);
            vy = ($urandom_range(0, 9) == 0) ? '0 : sized_val(24);
            for (int k = 0; k < 4; k++)
            begin
                t = int'($urandom_range(0, 8)) - 4;
                px[k] = ox + word_t'(t) * vx;
                py[k] = oy + word_t'(t) * vy;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                t = $urandom_range(0, 3);
                py[t] = py[t] + 1;
            end
        end
        else if (shape < 70)
        begin
            // C at A, at B or at the midpoint of AB
            ox = sized_val(2);
            oy = sized_val(2);
            vx = sized_val(4);
            vy = sized_val(4);
            px[PT_A] = ox;
            py[PT_A] = oy;
            px[PT_B] = ox + 2 * vx;
            py[PT_B] = oy + 2 * vy;
            t = $urandom_range(0, 2);
            t = (t == 2) ? 1 : 2 * t;
            px[PT_C] = ox + word_t'(t) * vx;
            py[PT_C] = oy + word_t'(t) * vy;
            px[PT_D] = sized_val(2);
            py[PT_D] = sized_val(2);
            if ($urandom_range(0, 1))
                swap_segments();
        end
        else if (shape < 80)
        begin
            // zero-length segment, on the other segment or not
            ox = sized_val(2);
            oy = sized_val(2);
            vx = sized_val(4);
            vy = sized_val(4);
            px[PT_C] = ox;
            py[PT_C] = oy;
            px[PT_D] = ox + 2 * vx;
            py[PT_D] = oy + 2 * vy;
            t = $urandom_range(0, 4);
            px[PT_A] = t[0] ? ox + vx : sized_val(2);
            py[PT_A] = t[0] ? oy + vy : sized_val(2);
            px[PT_B] = px[PT_A];
            py[PT_B] = py[PT_A];
            if (t == 4)
            begin
                px[PT_D] = $urandom_range(0, 1) ? px[PT_A] : px[PT_C];
                py[PT_D] = $urandom_range(0, 1) ? py[PT_A] : py[PT_C];
                px[PT_C] = px[PT_D];
                py[PT_C] = py[PT_D];
            end
            else if (t[1])
                swap_segments();
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                px[k] = corner_val();
                py[k] = corner_val();
            end
        end
    endtask

    task automatic offer(input int gap);
        ax <= px[PT_A];
        ay <= py[PT_A];
        bx <= px[PT_B];
        by <= py[PT_B];
        cx <= px[PT_C];
        cy <= py[PT_C];
        dx <= px[PT_D];
        dy <= py[PT_D];
        pair_valid <= 1'b1;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
        if (gap > 0)
        begin
            pair_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put(input word_t xa, input word_t ya, input word_t xb, input word_t yb,
                       input word_t xc, input word_t yc, input word_t xd, input word_t yd);
        px[PT_A] = xa; py[PT_A] = ya;
        px[PT_B] = xb; py[PT_B] = yb;
        px[PT_C] = xc; py[PT_C] = yc;
        px[PT_D] = xd; py[PT_D] = yd;
        offer(0);
    endtask

    task automatic settle();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int n;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                n = pause_len();
                repeat (n) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int gap;
        rst_n      = 1'b0;
        pair_valid = 1'b0;
        idle_on    = 1'b0;
        long_hold  = 1'b0;
        {ax, ay, bx, by, cx, cy, dx, dy} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        put(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        put(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        put(0, 0, 4, 4, 2, 2, 6, 6);
        put(0, 0, 4, 4, 4, 4, 6, 6);
        put(0, 0, 4, 4, 5, 5, 6, 6);
        put(0, 0, 0, 4, 0, 9, 0, 2);
        put(0, -4, 0, 4, 0, 5, 0, 9);
        put(0, -4, 0, 4, 0, 9, 0, 4);
        put(0, 0, 4, 4, 0, 4, 4, 0);
        put(0, 0, 4, 0, 2, 0, 2, 5);
        put(0, 0, 4, 0, 0, 1, 4, 1);
        put(2, 2, 2, 2, 0, 0, 4, 4);
        put(2, 3, 2, 3, 0, 0, 4, 4);
        put(1, 1, 1, 1, 1, 1, 1, 1);
        put(1, 1, 1, 1, 2, 2, 2, 2);
        put(0, 0, 4, 4, 2, 2, 2, 2);
        put(0, 0, 4, 4, 2, 3, 2, 3);
        put(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX);
        put(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, -1, -1, 0, 0);
        put(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, -1, 0, 5, 5);
        put(0, 0, COORD_MAX, COORD_MAX - 1, 1, 1, COORD_MAX - 1, COORD_MAX - 1);
        put(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, -1);
        put(COORD_MAX, 0, COORD_MIN + 1, 0, COORD_MIN, 0, COORD_MIN + 1, 0);
        settle();

        // results held back while pairs keep coming: the pipeline fills and stalls
        long_hold = 1'b1;
        repeat (60)
        begin
            make_pair();
            offer(0);
        end

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            idle_on = blk[0];
            repeat (BLOCK_PAIRS)
            begin
                make_pair();
                gap = (idle_on && $urandom_range(0, 1)) ? pause_len() : 0;
                offer(gap);
            end
            if (blk == BLOCKS / 2 - 1)
                settle();
        end
        settle();
        repeat (4 * NUM_STAGES) @(posedge clk);

        $display("Run covered %0d segment pair transfers: extremes, collinear, touching,",
                 pairs_seen);
        $display("zero-length and random shapes; relations disjoint %0d, crossing %0d, touch %0d, overlap %0d",
                 relation_hits[REL_DISJOINT], relation_hits[REL_CROSS],
                 relation_hits[REL_TOUCH], relation_hits[REL_OVERLAP]);
        if (fail_count == 0 && pending == 0)
            $display("segment_pair_classifier_top_test passed");
        else
            $display("segment_pair_classifier_top_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/spc_pkg.sv
sv/spc_mul.sv
sv/segment_pair_classifier_top.sv
tb/segment_pair_classifier_checker.sv
tb/segment_pair_classifier_top_test.sv
